### design/dense_matrix_multiply_defines.svh
// Assertion macros used by the checker file dmm_chk.sv.
`ifndef DENSE_MATRIX_MULTIPLY_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DMM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### design/dmm_pkg.sv
`default_nettype none

package dmm_pkg;

  // Command codes carried in the opcode field
  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_t;

  localparam int DimW      = 4;
  localparam int IdxFieldW = 3;
  localparam int ValueW    = 16;
  localparam int SumW      = 40;
  localparam int DrainW    = 2;
  // Final drain count: hold busy past the final issue,
  // until the final result has been shown
  localparam logic [DrainW-1:0] DrainLast = 2'd2;
  localparam logic [DimW-1:0]   DimReset  = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [IdxFieldW-1:0]    row;
    logic [IdxFieldW-1:0]    col;
    logic signed [ValueW-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IdxFieldW-1:0]   out_row;
    logic [IdxFieldW-1:0]   out_col;
    logic signed [SumW-1:0] sum;
    logic                   last;
  } out_item_t;

  // Effective matrix dimensions
  typedef struct packed {
    logic [DimW-1:0] nr;
    logic [DimW-1:0] nk;
    logic [DimW-1:0] nc;
  } dims_t;

  // Control that travels with each multiply-accumulate beat
  typedef struct packed {
    logic                 vld;
    logic                 first;
    logic                 fin;
    logic                 last;
    logic [IdxFieldW-1:0] row;
    logic [IdxFieldW-1:0] col;
  } mac_ctl_t;

  // Clamp a dimension register into 1..max_dim
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] raw,
                                               input logic [DimW-1:0] max_dim);
    logic [DimW-1:0] res;
    if (raw == '0) begin
      res = 4'd1;
    end else if (raw > max_dim) begin
      res = max_dim;
    end else begin
      res = raw;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### design/dmm_mem.sv
`default_nettype none

module dmm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [DEPTH];

  // Write one element
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/dmm_mac.sv
`default_nettype none

module dmm_mac #(
  parameter int ELEM_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire dmm_pkg::mac_ctl_t       ctl,
  input  wire logic [ELEM_BITS-1:0]    a_rdata,
  input  wire logic [ELEM_BITS-1:0]    b_rdata,
  output logic                         out_valid,
  output dmm_pkg::out_item_t           out_data
);

  import dmm_pkg::*;

  localparam int PW = 2 * ELEM_BITS;

  mac_ctl_t             s1_r, s1_nxt;
  mac_ctl_t             s2_r, s2_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [SumW-1:0] acc_r, acc_nxt;
  logic signed [SumW-1:0] prod_ext;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  // Multiply the operands read this beat, then sign-extend into the sum width and accumulate
  always_comb begin
    s1_nxt   = ctl;
    s2_nxt   = s1_r;
    prod_nxt = $signed(a_rdata) * $signed(b_rdata);
    prod_ext = SumW'({{64{prod_r[PW-1]}}, prod_r});
    acc_nxt  = (s2_r.first ? '0 : acc_r) + prod_ext;
  end

  // Emit a result on the final beat of each dot product
  always_comb begin
    out_valid_nxt = s2_r.vld & s2_r.fin;
    out_nxt       = out_r;
    if (s2_r.vld && s2_r.fin) begin
      out_nxt.out_row = s2_r.row;
      out_nxt.out_col = s2_r.col;
      out_nxt.sum     = acc_nxt;
      out_nxt.last    = s2_r.last;
    end
  end

  // Advance control stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= '0;
      s2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r        <= s1_nxt;
      s2_r        <= s2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold product, sum and result
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    out_r  <= out_nxt;
    if (s2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### design/dmm_seq.sv
`default_nettype none

module dmm_seq #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire dmm_pkg::dims_t  dims,
  output logic                 busy,
  output dmm_pkg::mac_ctl_t    ctl,
  output logic [AW-1:0]        a_raddr,
  output logic [AW-1:0]        b_raddr
);

  import dmm_pkg::*;

  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  seq_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [DrainW-1:0] drain_r, drain_nxt;
  logic              i_end, j_end, k_end;

  assign i_end = DimW'(i_r) == dims.nr - 4'd1;
  assign j_end = DimW'(j_r) == dims.nc - 4'd1;
  assign k_end = DimW'(k_r) == dims.nk - 4'd1;

  // Next state: walk i, then j, then k innermost, one beat a cycle
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
        end
      end
      ST_RUN: begin
        if (!k_end) begin
          k_nxt = k_r + 1'b1;
        end else begin
          k_nxt = '0;
          if (!j_end) begin
            j_nxt = j_r + 1'b1;
          end else begin
            j_nxt = '0;
            if (!i_end) begin
              i_nxt = i_r + 1'b1;
            end else begin
              state_nxt = ST_DRAIN;
              drain_nxt = '0;
            end
          end
        end
      end
      ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DrainLast) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= '0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
  end

  // Drive the beat issued this cycle
  always_comb begin
    ctl.vld   = state_r == ST_RUN;
    ctl.first = k_r == '0;
    ctl.fin   = k_end;
    ctl.last  = k_end & j_end & i_end;
    ctl.row   = IdxFieldW'(i_r);
    ctl.col   = IdxFieldW'(j_r);
    a_raddr   = AW'(i_r * MAX_DIM + k_r);
    b_raddr   = AW'(k_r * MAX_DIM + j_r);
  end

  assign busy = state_r != ST_IDLE;

endmodule

`default_nettype wire

### design/dense_matrix_multiply.sv
`default_nettype none

// Dense matrix multiplier C = A * B. Write elements of A (opcode 0) and B
// (opcode 1) one per start; each write leaves busy low. Writes outside the
// configured dimensions are dropped. A compute start (opcode 2) raises busy
// and emits every product element in row-major order, one out_valid beat
// each, the final one marked by last; the receiver cannot stall, so take
// every beat as it comes. A compute keeps busy high until its last result
// has been shown: one shared multiply-accumulate handles one inner-index
// term per cycle, and each term passes through registered read, multiply
// and add steps. Dimension registers reading 0 act as 1 and above MAX_DIM
// act as MAX_DIM; write them only while busy is low. Reading an element
// never written gives an undefined sum.
module dense_matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire dmm_pkg::in_item_t   in_data,
  output logic                     busy,
  output logic                     out_valid,
  output dmm_pkg::out_item_t       out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_idx,
  input  wire logic [3:0]          cfg_data
);

  import dmm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [DimW-1:0]      rows_a_r, inner_r, cols_b_r;
  dims_t                dims;
  logic                 accept;
  logic                 go;
  logic                 a_we, b_we;
  logic [AW-1:0]        waddr;
  logic [ELEM_BITS-1:0] wdata;
  logic [AW-1:0]        a_raddr, b_raddr;
  logic [ELEM_BITS-1:0] a_rdata, b_rdata;
  mac_ctl_t             ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DimReset;
      inner_r  <= DimReset;
      cols_b_r <= DimReset;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ROWS_A: rows_a_r <= cfg_data;
        CFG_INNER:  inner_r  <= cfg_data;
        CFG_COLS_B: cols_b_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_comb begin
    dims.nr = eff_dim(rows_a_r, DimW'(MAX_DIM));
    dims.nk = eff_dim(inner_r, DimW'(MAX_DIM));
    dims.nc = eff_dim(cols_b_r, DimW'(MAX_DIM));
  end

  // Decode accepted beats; drop writes outside the matrix
  always_comb begin
    accept = start & ~busy;
    go     = accept & (in_data.opcode == OP_COMPUTE);
    a_we   = accept & (in_data.opcode == OP_WRITE_A) &
             (DimW'(in_data.row) < dims.nr) & (DimW'(in_data.col) < dims.nk);
    b_we   = accept & (in_data.opcode == OP_WRITE_B) &
             (DimW'(in_data.row) < dims.nk) & (DimW'(in_data.col) < dims.nc);
    waddr  = AW'(in_data.row[IDX_W-1:0] * MAX_DIM + in_data.col[IDX_W-1:0]);
    wdata  = ELEM_BITS'({{ValueW{in_data.value[ValueW-1]}}, in_data.value});
  end

  dmm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ELEM_BITS)
  ) u_mem_a (
    .clk     (clk),
    .we      (a_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (a_raddr),
    .rdata_r (a_rdata)
  );

  dmm_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ELEM_BITS)
  ) u_mem_b (
    .clk     (clk),
    .we      (b_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (b_raddr),
    .rdata_r (b_rdata)
  );

  dmm_seq #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .dims    (dims),
    .busy    (busy),
    .ctl     (ctl),
    .a_raddr (a_raddr),
    .b_raddr (b_raddr)
  );

  dmm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### design/dmm_chk.sv
`default_nettype none

`include "dense_matrix_multiply_defines.svh"

module dmm_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire dmm_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire dmm_pkg::out_item_t out_data
);

  import dmm_pkg::*;

  logic take_compute;
  logic take_write;

  assign take_compute = start & ~busy & (in_data.opcode == OP_COMPUTE);
  assign take_write   = start & ~busy & (in_data.opcode != OP_COMPUTE);

  // Results appear only inside a compute run
  `DMM_ASSERT_NOW(a_out_in_run, out_valid, busy, "result beat outside a compute run")
  // A compute start occupies the block
  `DMM_ASSERT_NEXT(a_compute_busy, take_compute, busy, "compute start did not raise busy")
  // Writes and unused codes do not occupy the block or emit a result
  `DMM_ASSERT_NEXT(a_write_free, take_write, !busy && !out_valid, "write held the block")
  // The final result ends the run
  `DMM_ASSERT_NEXT(a_last_ends, out_valid && out_data.last, !busy, "run outlived last beat")

endmodule

bind dense_matrix_multiply dmm_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
